/* rtl/core/sla_pkg.sv */
// Shared types and constants for the segment list allocator.
// Used by the cell row, the pick logic, the top level and the checker.
package sla_pkg;

	localparam int MAX_SEGMENTS_DEF = 32;
	localparam int OFFSET_BITS_DEF  = 16;

	// Configuration register file
	localparam int REG_BITS      = 16;
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic [REG_BITS-1:0] REGION_SIZE_RESET = 16'hFFFF;
	// register index is paddr[2] (word address)
	localparam logic REG_REGION_SIZE = 1'b0;

	// Item operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [3:0] {
		CELL_HOLD,
		CELL_CLAIM,      // mark allocated
		CELL_CUT,        // keep the requested length, mark allocated
		CELL_TAIL,       // free remainder of the left neighbor
		CELL_FROM_LEFT,  // shift up by one
		CELL_SET_FREE,
		CELL_MERGE1,     // absorb right neighbor
		CELL_MERGE2,     // absorb two right neighbors
		CELL_FROM_R1,    // shift down by one
		CELL_FROM_R2,    // shift down by two
		CELL_LOAD_HEAD,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		logic valid;
		logic free;
		logic exact;
		logic big;
		logic hit;
	} cell_stat_t;

	typedef struct packed {
		logic ok;
		logic grant;
	} pick_t;

endpackage

/* rtl/core/segment_list_allocator.sv */
// Segment list allocator: first fit with exact-size priority and coalescing.
// Per word: a compare in every cell of the row (ST_CMP), then a priority pick and
// a shift of the row by one or two places for split or merge (ST_APPLY), held while
// the output stalls; the next word is taken as the result enters the output register.
// Reset: region size 65535, table holds one free segment at offset 0; no sweep.
// Depends on sla_pkg, sla_cell and sla_pick.
module segment_list_allocator #(
	parameter int MAX_SEGMENTS = sla_pkg::MAX_SEGMENTS_DEF,
	parameter int OFFSET_BITS  = sla_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sla_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [sla_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [sla_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [OFFSET_BITS-1:0]            request_size,
	input  logic [OFFSET_BITS-1:0]            block_offset,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [OFFSET_BITS-1:0]            granted_offset,
	output logic                              success
);

	typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_APPLY} state_t;

	state_t                     state_q;
	logic [sla_pkg::REG_BITS-1:0] region_q;
	logic                       op_q;
	logic [OFFSET_BITS-1:0]     req_q, ofs_q;
	logic                       out_valid_q, success_q;
	logic [OFFSET_BITS-1:0]     granted_q;
	logic                       cfg_wr, can_finish, apply, in_acc;
	logic [OFFSET_BITS-1:0]     region_len, grant_start;

	logic [OFFSET_BITS-1:0]     seg_start [MAX_SEGMENTS];
	logic [OFFSET_BITS-1:0]     seg_len   [MAX_SEGMENTS];
	logic                       seg_free  [MAX_SEGMENTS];
	logic                       seg_valid [MAX_SEGMENTS];
	sla_pkg::cell_stat_t        stat      [MAX_SEGMENTS];
	sla_pkg::cell_op_t          ops       [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0]    sel;
	sla_pkg::pick_t             pick;

	// configuration port
	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && (paddr[2] == sla_pkg::REG_REGION_SIZE);
	assign prdata     = sla_pkg::APB_DATA_BITS'(region_q);
	// head cell loads the value being written in the same edge
	assign region_len = OFFSET_BITS'(pwdata[sla_pkg::REG_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			region_q <= sla_pkg::REGION_SIZE_RESET;
		else if (cfg_wr)
			region_q <= pwdata[sla_pkg::REG_BITS-1:0];
	end

	// handshake
	assign can_finish = !out_valid_q || !out_stall;
	assign apply      = (state_q == ST_APPLY) && can_finish;
	assign in_stall   = !((state_q == ST_IDLE) || apply);
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign granted_offset = granted_q;
	assign success    = success_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= operation;
			req_q <= request_size;
			ofs_q <= block_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			success_q   <= 1'b0;
			granted_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_acc) state_q <= ST_CMP;
				ST_CMP:   state_q <= ST_APPLY;
				ST_APPLY: if (can_finish) state_q <= in_acc ? ST_CMP : ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if (apply) begin
				out_valid_q <= 1'b1;
				success_q   <= pick.ok;
				granted_q   <= pick.grant ? grant_start : '0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// start of the picked cell, one-hot select
	always_comb begin
		grant_start = '0;
		for (int k = 0; k < MAX_SEGMENTS; k++)
			grant_start = grant_start | (sel[k] ? seg_start[k] : '0);
	end

	sla_pick #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_pick (
		.stat      (stat),
		.init      (cfg_wr),
		.apply     (apply),
		.operation (op_q),
		.req_zero  (req_q == '0),
		.ops       (ops),
		.sel       (sel),
		.pick      (pick)
	);

	for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
		logic [OFFSET_BITS-1:0] l_start, l_len, a_start, a_len, b_start, b_len;
		logic                   l_free, l_valid, a_free, a_valid, b_free, b_valid;

		if (k == 0) begin : g_l0
			assign l_start = '0;
			assign l_len   = '0;
			assign l_free  = 1'b0;
			assign l_valid = 1'b0;
		end else begin : g_l
			assign l_start = seg_start[k-1];
			assign l_len   = seg_len[k-1];
			assign l_free  = seg_free[k-1];
			assign l_valid = seg_valid[k-1];
		end

		if (k + 1 < MAX_SEGMENTS) begin : g_r1
			assign a_start = seg_start[k+1];
			assign a_len   = seg_len[k+1];
			assign a_free  = seg_free[k+1];
			assign a_valid = seg_valid[k+1];
		end else begin : g_r1z
			assign a_start = '0;
			assign a_len   = '0;
			assign a_free  = 1'b0;
			assign a_valid = 1'b0;
		end

		if (k + 2 < MAX_SEGMENTS) begin : g_r2
			assign b_start = seg_start[k+2];
			assign b_len   = seg_len[k+2];
			assign b_free  = seg_free[k+2];
			assign b_valid = seg_valid[k+2];
		end else begin : g_r2z
			assign b_start = '0;
			assign b_len   = '0;
			assign b_free  = 1'b0;
			assign b_valid = 1'b0;
		end

		sla_cell #(.OFFSET_BITS(OFFSET_BITS), .IS_HEAD(k == 0)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmp_en     (state_q == ST_CMP),
			.op         (ops[k]),
			.req        (req_q),
			.ofs        (ofs_q),
			.region_len (region_len),
			.left_start (l_start),
			.left_len   (l_len),
			.left_free  (l_free),
			.left_valid (l_valid),
			.r1_start   (a_start),
			.r1_len     (a_len),
			.r1_free    (a_free),
			.r1_valid   (a_valid),
			.r2_start   (b_start),
			.r2_len     (b_len),
			.r2_free    (b_free),
			.r2_valid   (b_valid),
			.seg_start  (seg_start[k]),
			.seg_len    (seg_len[k]),
			.seg_free   (seg_free[k]),
			.seg_valid  (seg_valid[k]),
			.stat       (stat[k])
		);
	end

endmodule

/* rtl/core/sla_cell.sv */
// One segment entry of the allocator table plus its compare flags.
// Depends on sla_pkg; neighbors feed it through the row built in the top level.
module sla_cell #(
	parameter int   OFFSET_BITS = sla_pkg::OFFSET_BITS_DEF,
	parameter bit   IS_HEAD     = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmp_en,
	input  sla_pkg::cell_op_t      op,
	input  logic [OFFSET_BITS-1:0] req,
	input  logic [OFFSET_BITS-1:0] ofs,
	input  logic [OFFSET_BITS-1:0] region_len,
	input  logic [OFFSET_BITS-1:0] left_start,
	input  logic [OFFSET_BITS-1:0] left_len,
	input  logic                   left_free,
	input  logic                   left_valid,
	input  logic [OFFSET_BITS-1:0] r1_start,
	input  logic [OFFSET_BITS-1:0] r1_len,
	input  logic                   r1_free,
	input  logic                   r1_valid,
	input  logic [OFFSET_BITS-1:0] r2_start,
	input  logic [OFFSET_BITS-1:0] r2_len,
	input  logic                   r2_free,
	input  logic                   r2_valid,
	output logic [OFFSET_BITS-1:0] seg_start,
	output logic [OFFSET_BITS-1:0] seg_len,
	output logic                   seg_free,
	output logic                   seg_valid,
	output sla_pkg::cell_stat_t    stat
);

	logic [OFFSET_BITS-1:0] start_q, len_q;
	logic                   free_q, valid_q;
	logic                   exact_s1, big_s1, hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			len_q    <= IS_HEAD ? OFFSET_BITS'(sla_pkg::REGION_SIZE_RESET) : '0;
			free_q   <= IS_HEAD;
			valid_q  <= IS_HEAD;
			exact_s1 <= 1'b0;
			big_s1   <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			if (cmp_en) begin
				exact_s1 <= valid_q && free_q && (len_q == req);
				big_s1   <= valid_q && free_q && (len_q > req);
				hit_s1   <= valid_q && (start_q == ofs);
			end
			case (op)
				sla_pkg::CELL_CLAIM: free_q <= 1'b0;
				sla_pkg::CELL_CUT: begin
					len_q  <= req;
					free_q <= 1'b0;
				end
				sla_pkg::CELL_TAIL: begin
					start_q <= left_start + req;
					len_q   <= left_len - req;
					free_q  <= 1'b1;
					valid_q <= 1'b1;
				end
				sla_pkg::CELL_FROM_LEFT: begin
					// free and valid marks travel with the word
					start_q <= left_start;
					len_q   <= left_len;
					free_q  <= left_free;
					valid_q <= left_valid;
				end
				sla_pkg::CELL_SET_FREE: free_q <= 1'b1;
				sla_pkg::CELL_MERGE1: begin
					len_q  <= len_q + r1_len;
					free_q <= 1'b1;
				end
				sla_pkg::CELL_MERGE2: begin
					len_q  <= len_q + r1_len + r2_len;
					free_q <= 1'b1;
				end
				sla_pkg::CELL_FROM_R1: begin
					start_q <= r1_start;
					len_q   <= r1_len;
					free_q  <= r1_free;
					valid_q <= r1_valid;
				end
				sla_pkg::CELL_FROM_R2: begin
					start_q <= r2_start;
					len_q   <= r2_len;
					free_q  <= r2_free;
					valid_q <= r2_valid;
				end
				sla_pkg::CELL_LOAD_HEAD: begin
					start_q <= '0;
					len_q   <= region_len;
					free_q  <= 1'b1;
					valid_q <= 1'b1;
				end
				sla_pkg::CELL_CLEAR: begin
					start_q <= '0;
					len_q   <= '0;
					free_q  <= 1'b0;
					valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign seg_start = start_q;
	assign seg_len   = len_q;
	assign seg_free  = free_q;
	assign seg_valid = valid_q;
	assign stat      = '{valid: valid_q, free: free_q, exact: exact_s1, big: big_s1,
		hit: hit_s1};

endmodule

/* rtl/core/sla_pick.sv */
// Priority pick over the cell flags and per-cell command decode.
// Depends on sla_pkg; drives the op of every sla_cell in the row.
module sla_pick #(
	parameter int MAX_SEGMENTS = sla_pkg::MAX_SEGMENTS_DEF
) (
	input  sla_pkg::cell_stat_t stat [MAX_SEGMENTS],
	input  logic                init,
	input  logic                apply,
	input  logic                operation,
	input  logic                req_zero,
	output sla_pkg::cell_op_t   ops  [MAX_SEGMENTS],
	output logic [MAX_SEGMENTS-1:0] sel,
	output sla_pkg::pick_t      pick
);

	logic [MAX_SEGMENTS-1:0] ex, bg, ht, fr, vl;
	logic [MAX_SEGMENTS-1:0] ex_first, bg_first, ht_first;
	logic [MAX_SEGMENTS-1:0] above, ge, sel_up, sel_dn, nb_r, nb_l;
	logic alloc, full, do_claim, do_split, do_free, mr, ml;

	always_comb begin
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			ex[k] = stat[k].exact;
			bg[k] = stat[k].big;
			ht[k] = stat[k].hit;
			fr[k] = stat[k].free;
			vl[k] = stat[k].valid;
		end
	end

	// lowest set bit of the exact, big and hit flag vectors
	assign ex_first = ex & (~ex + MAX_SEGMENTS'(1));
	assign bg_first = bg & (~bg + MAX_SEGMENTS'(1));
	assign ht_first = ht & (~ht + MAX_SEGMENTS'(1));

	assign full     = vl[MAX_SEGMENTS-1];
	assign alloc    = (operation == sla_pkg::OP_ALLOC) && !req_zero;
	assign do_claim = alloc && (|ex);
	assign do_split = alloc && !(|ex) && (|bg) && !full;
	assign do_free  = (operation == sla_pkg::OP_FREE) && (|ht);

	always_comb begin
		if (do_claim)
			sel = ex_first;
		else if (do_split)
			sel = bg_first;
		else if (do_free)
			sel = ht_first;
		else
			sel = '0;
	end

	assign above  = ~(sel | (sel - MAX_SEGMENTS'(1)));
	assign ge     = sel | above;
	assign sel_up = sel << 1;
	assign sel_dn = sel >> 1;
	assign nb_r   = {1'b0, vl[MAX_SEGMENTS-1:1] & fr[MAX_SEGMENTS-1:1]};
	assign nb_l   = {fr[MAX_SEGMENTS-2:0], 1'b0};
	assign mr     = |(sel & nb_r);
	assign ml     = |(sel & nb_l);

	always_comb begin
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			ops[k] = sla_pkg::CELL_HOLD;
			if (init) begin
				ops[k] = (k == 0) ? sla_pkg::CELL_LOAD_HEAD : sla_pkg::CELL_CLEAR;
			end else if (apply) begin
				if (do_claim) begin
					if (sel[k])
						ops[k] = sla_pkg::CELL_CLAIM;
				end else if (do_split) begin
					if (sel[k])
						ops[k] = sla_pkg::CELL_CUT;
					else if (sel_up[k])
						ops[k] = sla_pkg::CELL_TAIL;
					else if (above[k])
						ops[k] = sla_pkg::CELL_FROM_LEFT;
				end else if (do_free) begin
					case ({ml, mr})
						2'b00: if (sel[k]) ops[k] = sla_pkg::CELL_SET_FREE;
						2'b01: begin
							if (sel[k])
								ops[k] = sla_pkg::CELL_MERGE1;
							else if (above[k])
								ops[k] = sla_pkg::CELL_FROM_R1;
						end
						2'b10: begin
							if (sel_dn[k])
								ops[k] = sla_pkg::CELL_MERGE1;
							else if (ge[k])
								ops[k] = sla_pkg::CELL_FROM_R1;
						end
						default: begin
							if (sel_dn[k])
								ops[k] = sla_pkg::CELL_MERGE2;
							else if (ge[k])
								ops[k] = sla_pkg::CELL_FROM_R2;
						end
					endcase
				end
			end
		end
	end

	assign pick = '{ok: do_claim || do_split || do_free, grant: do_claim || do_split};

endmodule

/* rtl/core/sla_checker.sv */
// Port-level checks for the segment list allocator, bound to the top level.
// Depends on sla_pkg for the port widths.
module sla_checker #(
	parameter int OFFSET_BITS = sla_pkg::OFFSET_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [OFFSET_BITS-1:0] granted_offset,
	input logic                   success
);

	// a failed word never carries an offset (a free word carries none either, unchecked here)
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> granted_offset == '0)
		else $error("failed word carries a nonzero offset");

	// the compare cycle always follows a taken word
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in the compare cycle");

	// a result word is pending once a taken input word has passed ST_CMP and ST_APPLY
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##3 out_valid)
		else $error("result word missing");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_offset) && $stable(success))
		else $error("stalled result word changed");

endmodule

bind segment_list_allocator sla_checker #(.OFFSET_BITS(OFFSET_BITS)) u_sla_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.granted_offset (granted_offset),
	.success        (success)
);
